// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. The synthesis view expands them to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/fha_pkg.sv =====
package fha_pkg;

    localparam int ARENA_BYTES  = 2048;
    localparam int HEADER_BYTES = 16;

    localparam int FIELD_W  = 11;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = $clog2(ARENA_BYTES);
    localparam int LINK_W   = ADDR_W + 1;
    localparam int SIZE_W   = ADDR_W;
    localparam int NEED_W   = FIELD_W + 1;
    localparam int CALC_W   = ((LINK_W > NEED_W) ? LINK_W : NEED_W) + 1;
    localparam int CNT_W    = $clog2(2 * ARENA_BYTES) + 1;

    localparam logic [LINK_W-1:0] LINK_NULL  = LINK_W'(ARENA_BYTES);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADBLK = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FBAD,
        S_AWALK,
        S_AEVAL,
        S_AW1,
        S_AW2,
        S_AW3,
        S_FWALK,
        S_FEVAL,
        S_FHEAD,
        S_MSTART,
        S_MLOAD,
        S_MCHK,
        S_MEVAL,
        S_RESULT
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RD_CUR,
        CMD_ADV,
        CMD_A_FAIL,
        CMD_A_TAKE,
        CMD_A_W1,
        CMD_A_W2,
        CMD_A_W3,
        CMD_F_BAD,
        CMD_F_LINK,
        CMD_F_HEAD,
        CMD_M_START,
        CMD_M_LOAD,
        CMD_M_RDNX,
        CMD_M_STEP,
        CMD_OUT_LOAD
    } cmd_t;

    typedef struct packed {
        logic in_free;
        logic free_bad;
        logic cur_null;
        logic walk_limit;
        logic fit;
        logic fwalk_go;
        logic head_null;
        logic merge_done;
    } dp_status_t;

    function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] v);
        return (v >= LINK_NULL) ? LINK_NULL : v;
    endfunction

endpackage

// ===== hw/rtl/fha_if.sv =====
interface fha_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [fha_pkg::FIELD_W-1:0] request_size;
    logic [fha_pkg::FIELD_W-1:0] block_address;

    modport source (output valid, output operation, output request_size,
                    output block_address, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input block_address, output ready);
endinterface

interface fha_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fha_pkg::STATUS_W-1:0] status;
    logic [fha_pkg::FIELD_W-1:0]  payload_address;
    logic [fha_pkg::FIELD_W-1:0]  block_bytes;

    modport source (output valid, output status, output payload_address,
                    output block_bytes, input ready);
    modport sink   (input valid, input status, input payload_address,
                    input block_bytes, output ready);
endinterface

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a 2048-byte arena with 16-byte block headers.
// The request channel carries one transaction per operation: allocate
// (request_size payload bytes) or free (block_address payload offset).
// The response channel returns one transaction per request with status,
// payload_address and block_bytes.
// Requests are handled one at a time. An allocate walks the free list to the
// first block that fits, then writes any remainder header, the granted header
// and the predecessor link, or is refused at the end of the list. A free walks
// to its insertion point, links the block in and merges touching neighbours;
// a bad free goes straight to the result. The next request can be taken in the
// cycle in which the response turns valid. Sizes and links sit in two memories
// with a write port each and one shared registered read port, read once per step.
// The response sits in an output register, so a new request is taken while
// an earlier response is still waiting; if the receiver stalls, a finished
// result holds in the controller until the register frees up.
// Reset is immediate: the whole arena becomes one free block, with no
// clearing pass over the header store.
`include "assert_macros.svh"

module first_fit_heap_allocator (
    input  logic           clk,
    input  logic           rst_n,
    fha_req_if.sink        request,
    fha_rsp_if.source      response
);

    fha_pkg::cmd_t       cmd;
    fha_pkg::dp_status_t st;

    fha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .st        (st),
        .cmd       (cmd)
    );

    fha_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .in_operation        (request.operation),
        .in_request_size     (request.request_size),
        .in_block_address    (request.block_address),
        .st                  (st),
        .out_status          (response.status),
        .out_payload_address (response.payload_address),
        .out_block_bytes     (response.block_bytes)
    );

    `ASSERT_NEXT(a_one_request_in_flight, clk, rst_n, request.valid && request.ready, !request.ready, "request accepted while another is in progress")
    `ASSERT_ALWAYS(a_failure_has_no_address, clk, rst_n, !response.valid || response.status == fha_pkg::STATUS_DONE || response.payload_address == '0, "failed request returned an address")
    `ASSERT_ALWAYS(a_address_past_header, clk, rst_n, !response.valid || response.payload_address == '0 || response.payload_address >= fha_pkg::HEADER_BYTES, "payload address inside a header")

endmodule

// ===== hw/rtl/fha_dp.sv =====
module fha_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fha_pkg::cmd_t                cmd,
    input  logic                         in_operation,
    input  logic [fha_pkg::FIELD_W-1:0]  in_request_size,
    input  logic [fha_pkg::FIELD_W-1:0]  in_block_address,
    output fha_pkg::dp_status_t          st,
    output logic [fha_pkg::STATUS_W-1:0] out_status,
    output logic [fha_pkg::FIELD_W-1:0]  out_payload_address,
    output logic [fha_pkg::FIELD_W-1:0]  out_block_bytes
);

    localparam int ADDR_W = fha_pkg::ADDR_W;
    localparam int LINK_W = fha_pkg::LINK_W;
    localparam int SIZE_W = fha_pkg::SIZE_W;
    localparam int CALC_W = fha_pkg::CALC_W;
    localparam int CNT_W  = fha_pkg::CNT_W;
    localparam logic [CALC_W-1:0] HDR = CALC_W'(fha_pkg::HEADER_BYTES);

    logic [SIZE_W-1:0] size_mem [fha_pkg::ARENA_BYTES];
    logic [LINK_W-1:0] link_mem [fha_pkg::ARENA_BYTES];

    logic [fha_pkg::FIELD_W-1:0]  req_reg, req_next;
    logic [CALC_W-1:0]            need_reg, need_next;
    logic [LINK_W-1:0]            blk_reg, blk_next;
    logic [LINK_W-1:0]            head_reg, head_next;
    logic [LINK_W-1:0]            cur_reg, cur_next;
    logic [LINK_W-1:0]            prev_reg, prev_next;
    logic [LINK_W-1:0]            nxt_reg, nxt_next;
    logic [SIZE_W-1:0]            sz_reg, sz_next;
    logic [LINK_W-1:0]            lk_reg, lk_next;
    logic [CNT_W-1:0]             steps_reg, steps_next;
    logic [fha_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [fha_pkg::FIELD_W-1:0]  res_payload_reg, res_payload_next;
    logic [fha_pkg::FIELD_W-1:0]  res_bytes_reg, res_bytes_next;
    logic [fha_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [fha_pkg::FIELD_W-1:0]  out_payload_reg, out_payload_next;
    logic [fha_pkg::FIELD_W-1:0]  out_bytes_reg, out_bytes_next;

    // Entry 0 holds the initial arena block until it is first written.
    logic sz0_wr_reg, lk0_wr_reg;

    logic              sz_we, lk_we, rd_en;
    logic [ADDR_W-1:0] sz_wa, lk_wa, rd_a;
    logic [SIZE_W-1:0] sz_wd;
    logic [LINK_W-1:0] lk_wd;
    logic [SIZE_W-1:0] sz_q;
    logic [LINK_W-1:0] lk_q;
    logic              rd0_sz_q, rd0_lk_q;
    logic [SIZE_W-1:0] rd_sz;
    logic [LINK_W-1:0] rd_lk;

    logic              split;
    logic [CALC_W-1:0] split_at;
    logic              adjacent;
    logic [CALC_W-1:0] merged;

    assign rd_sz = rd0_sz_q ? fha_pkg::SIZE_RESET : sz_q;
    assign rd_lk = rd0_lk_q ? fha_pkg::LINK_NULL : lk_q;

    always_ff @(posedge clk)
    begin
        if (sz_we)
        begin
            size_mem[sz_wa] <= sz_wd;
        end
        if (lk_we)
        begin
            link_mem[lk_wa] <= lk_wd;
        end
        if (rd_en)
        begin
            sz_q     <= size_mem[rd_a];
            lk_q     <= link_mem[rd_a];
            rd0_sz_q <= (rd_a == '0) && !sz0_wr_reg;
            rd0_lk_q <= (rd_a == '0) && !lk0_wr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sz0_wr_reg <= 1'b0;
            lk0_wr_reg <= 1'b0;
            head_reg   <= '0;
        end
        else
        begin
            if (sz_we && sz_wa == '0)
            begin
                sz0_wr_reg <= 1'b1;
            end
            if (lk_we && lk_wa == '0)
            begin
                lk0_wr_reg <= 1'b1;
            end
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        need_reg        <= need_next;
        blk_reg         <= blk_next;
        cur_reg         <= cur_next;
        prev_reg        <= prev_next;
        nxt_reg         <= nxt_next;
        sz_reg          <= sz_next;
        lk_reg          <= lk_next;
        steps_reg       <= steps_next;
        res_status_reg  <= res_status_next;
        res_payload_reg <= res_payload_next;
        res_bytes_reg   <= res_bytes_next;
        out_status_reg  <= out_status_next;
        out_payload_reg <= out_payload_next;
        out_bytes_reg   <= out_bytes_next;
    end

    assign split    = CALC_W'(sz_reg) != need_reg;
    assign split_at = CALC_W'(cur_reg) + need_reg;
    assign adjacent = (CALC_W'(cur_reg) + CALC_W'(sz_reg) + HDR) == CALC_W'(lk_reg);
    assign merged   = CALC_W'(sz_reg) + CALC_W'(rd_sz) + HDR;

    always_comb
    begin
        req_next         = req_reg;
        need_next        = need_reg;
        blk_next         = blk_reg;
        head_next        = head_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        nxt_next         = nxt_reg;
        sz_next          = sz_reg;
        lk_next          = lk_reg;
        steps_next       = steps_reg;
        res_status_next  = res_status_reg;
        res_payload_next = res_payload_reg;
        res_bytes_next   = res_bytes_reg;
        out_status_next  = out_status_reg;
        out_payload_next = out_payload_reg;
        out_bytes_next   = out_bytes_reg;
        sz_we = 1'b0;
        sz_wa = '0;
        sz_wd = '0;
        lk_we = 1'b0;
        lk_wa = '0;
        lk_wd = '0;
        rd_en = 1'b0;
        rd_a  = '0;

        case (cmd)
            fha_pkg::CMD_LOAD:
            begin
                req_next   = in_request_size;
                need_next  = CALC_W'(in_request_size) + HDR;
                blk_next   = LINK_W'(in_block_address)
                             - LINK_W'(fha_pkg::HEADER_BYTES);
                cur_next   = fha_pkg::norm_link(head_reg);
                prev_next  = fha_pkg::LINK_NULL;
                steps_next = '0;
            end
            fha_pkg::CMD_RD_CUR:
            begin
                rd_en = 1'b1;
                rd_a  = cur_reg[ADDR_W-1:0];
            end
            fha_pkg::CMD_ADV:
            begin
                prev_next  = cur_reg;
                cur_next   = fha_pkg::norm_link(rd_lk);
                steps_next = steps_reg + CNT_W'(1);
            end
            fha_pkg::CMD_A_FAIL:
            begin
                res_status_next  = fha_pkg::STATUS_NOMEM;
                res_payload_next = '0;
                res_bytes_next   = '0;
            end
            fha_pkg::CMD_A_TAKE:
            begin
                sz_next = rd_sz;
                lk_next = fha_pkg::norm_link(rd_lk);
            end
            fha_pkg::CMD_A_W1:
            begin
                // The remainder header goes right after the granted payload.
                if (split)
                begin
                    sz_we    = 1'b1;
                    sz_wa    = split_at[ADDR_W-1:0];
                    sz_wd    = SIZE_W'(CALC_W'(sz_reg) - need_reg);
                    lk_we    = 1'b1;
                    lk_wa    = split_at[ADDR_W-1:0];
                    lk_wd    = lk_reg;
                    nxt_next = LINK_W'(split_at);
                end
                else
                begin
                    nxt_next = lk_reg;
                end
            end
            fha_pkg::CMD_A_W2:
            begin
                if (split)
                begin
                    sz_we = 1'b1;
                    sz_wa = cur_reg[ADDR_W-1:0];
                    sz_wd = SIZE_W'(req_reg);
                end
                lk_we = 1'b1;
                lk_wa = cur_reg[ADDR_W-1:0];
                lk_wd = fha_pkg::LINK_NULL;
            end
            fha_pkg::CMD_A_W3:
            begin
                if (prev_reg == fha_pkg::LINK_NULL)
                begin
                    head_next = nxt_reg;
                end
                else
                begin
                    lk_we = 1'b1;
                    lk_wa = prev_reg[ADDR_W-1:0];
                    lk_wd = nxt_reg;
                end
                res_status_next  = fha_pkg::STATUS_DONE;
                res_payload_next = fha_pkg::FIELD_W'(CALC_W'(cur_reg) + HDR);
                res_bytes_next   = req_reg;
            end
            fha_pkg::CMD_F_BAD:
            begin
                res_status_next  = fha_pkg::STATUS_BADBLK;
                res_payload_next = '0;
                res_bytes_next   = '0;
            end
            fha_pkg::CMD_F_LINK:
            begin
                lk_we = 1'b1;
                lk_wa = blk_reg[ADDR_W-1:0];
                lk_wd = cur_reg;
                rd_en = 1'b1;
                rd_a  = blk_reg[ADDR_W-1:0];
            end
            fha_pkg::CMD_F_HEAD:
            begin
                if (prev_reg == fha_pkg::LINK_NULL)
                begin
                    head_next = blk_reg;
                end
                else
                begin
                    lk_we = 1'b1;
                    lk_wa = prev_reg[ADDR_W-1:0];
                    lk_wd = blk_reg;
                end
                res_status_next  = fha_pkg::STATUS_DONE;
                res_payload_next = '0;
                res_bytes_next   = fha_pkg::FIELD_W'(rd_sz);
            end
            fha_pkg::CMD_M_START:
            begin
                rd_en      = 1'b1;
                rd_a       = head_reg[ADDR_W-1:0];
                cur_next   = head_reg;
                steps_next = '0;
            end
            fha_pkg::CMD_M_LOAD:
            begin
                sz_next = rd_sz;
                lk_next = rd_lk;
            end
            fha_pkg::CMD_M_RDNX:
            begin
                rd_en = 1'b1;
                rd_a  = lk_reg[ADDR_W-1:0];
            end
            fha_pkg::CMD_M_STEP:
            begin
                // Current and next block are kept in registers so that each merge
                // step reads only the successor's header.
                if (adjacent)
                begin
                    sz_we   = 1'b1;
                    sz_wa   = cur_reg[ADDR_W-1:0];
                    sz_wd   = SIZE_W'(merged);
                    lk_we   = 1'b1;
                    lk_wa   = cur_reg[ADDR_W-1:0];
                    lk_wd   = fha_pkg::norm_link(rd_lk);
                    sz_next = SIZE_W'(merged);
                    lk_next = fha_pkg::norm_link(rd_lk);
                end
                else
                begin
                    cur_next = lk_reg;
                    sz_next  = rd_sz;
                    lk_next  = rd_lk;
                end
                steps_next = steps_reg + CNT_W'(1);
            end
            fha_pkg::CMD_OUT_LOAD:
            begin
                out_status_next  = res_status_reg;
                out_payload_next = res_payload_reg;
                out_bytes_next   = res_bytes_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.in_free    = in_operation == fha_pkg::OP_FREE;
        st.free_bad   = (CALC_W'(in_block_address) < HDR)
                        || ((CALC_W'(in_block_address) - HDR)
                            >= CALC_W'(fha_pkg::ARENA_BYTES));
        st.cur_null   = cur_reg >= fha_pkg::LINK_NULL;
        st.walk_limit = steps_reg >= CNT_W'(fha_pkg::ARENA_BYTES);
        st.fit        = (CALC_W'(rd_sz) == need_reg)
                        || ((CALC_W'(rd_sz) > need_reg)
                            && (split_at < CALC_W'(fha_pkg::ARENA_BYTES)));
        st.fwalk_go   = (cur_reg < fha_pkg::LINK_NULL) && (cur_reg < blk_reg)
                        && (steps_reg < CNT_W'(fha_pkg::ARENA_BYTES));
        st.head_null  = head_reg >= fha_pkg::LINK_NULL;
        st.merge_done = (lk_reg >= fha_pkg::LINK_NULL)
                        || (steps_reg >= CNT_W'(2 * fha_pkg::ARENA_BYTES));
    end

    assign out_status          = out_status_reg;
    assign out_payload_address = out_payload_reg;
    assign out_block_bytes     = out_bytes_reg;

endmodule

// ===== hw/rtl/fha_ctrl.sv =====
module fha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  fha_pkg::dp_status_t st,
    output fha_pkg::cmd_t       cmd
);

    fha_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fha_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = fha_pkg::CMD_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            fha_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = fha_pkg::CMD_LOAD;
                    if (!st.in_free)
                    begin
                        state_next = fha_pkg::S_AWALK;
                    end
                    else if (st.free_bad)
                    begin
                        state_next = fha_pkg::S_FBAD;
                    end
                    else
                    begin
                        state_next = fha_pkg::S_FWALK;
                    end
                end
            end
            fha_pkg::S_FBAD:
            begin
                cmd        = fha_pkg::CMD_F_BAD;
                state_next = fha_pkg::S_RESULT;
            end
            fha_pkg::S_AWALK:
            begin
                if (st.cur_null || st.walk_limit)
                begin
                    cmd        = fha_pkg::CMD_A_FAIL;
                    state_next = fha_pkg::S_RESULT;
                end
                else
                begin
                    cmd        = fha_pkg::CMD_RD_CUR;
                    state_next = fha_pkg::S_AEVAL;
                end
            end
            fha_pkg::S_AEVAL:
            begin
                if (st.fit)
                begin
                    cmd        = fha_pkg::CMD_A_TAKE;
                    state_next = fha_pkg::S_AW1;
                end
                else
                begin
                    cmd        = fha_pkg::CMD_ADV;
                    state_next = fha_pkg::S_AWALK;
                end
            end
            fha_pkg::S_AW1:
            begin
                cmd        = fha_pkg::CMD_A_W1;
                state_next = fha_pkg::S_AW2;
            end
            fha_pkg::S_AW2:
            begin
                cmd        = fha_pkg::CMD_A_W2;
                state_next = fha_pkg::S_AW3;
            end
            fha_pkg::S_AW3:
            begin
                cmd        = fha_pkg::CMD_A_W3;
                state_next = fha_pkg::S_RESULT;
            end
            fha_pkg::S_FWALK:
            begin
                if (st.fwalk_go)
                begin
                    cmd        = fha_pkg::CMD_RD_CUR;
                    state_next = fha_pkg::S_FEVAL;
                end
                else
                begin
                    cmd        = fha_pkg::CMD_F_LINK;
                    state_next = fha_pkg::S_FHEAD;
                end
            end
            fha_pkg::S_FEVAL:
            begin
                cmd        = fha_pkg::CMD_ADV;
                state_next = fha_pkg::S_FWALK;
            end
            fha_pkg::S_FHEAD:
            begin
                cmd        = fha_pkg::CMD_F_HEAD;
                state_next = fha_pkg::S_MSTART;
            end
            fha_pkg::S_MSTART:
            begin
                if (st.head_null)
                begin
                    state_next = fha_pkg::S_RESULT;
                end
                else
                begin
                    cmd        = fha_pkg::CMD_M_START;
                    state_next = fha_pkg::S_MLOAD;
                end
            end
            fha_pkg::S_MLOAD:
            begin
                cmd        = fha_pkg::CMD_M_LOAD;
                state_next = fha_pkg::S_MCHK;
            end
            fha_pkg::S_MCHK:
            begin
                if (st.merge_done)
                begin
                    state_next = fha_pkg::S_RESULT;
                end
                else
                begin
                    cmd        = fha_pkg::CMD_M_RDNX;
                    state_next = fha_pkg::S_MEVAL;
                end
            end
            fha_pkg::S_MEVAL:
            begin
                cmd        = fha_pkg::CMD_M_STEP;
                state_next = fha_pkg::S_MCHK;
            end
            fha_pkg::S_RESULT:
            begin
                // The result waits here only while the output register is full and not being taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = fha_pkg::CMD_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = fha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fha_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== tb/sv/fha_checker.sv =====
module fha_checker (
    input  logic clk,
    input  logic rst_n,
    fha_req_if   request,
    fha_rsp_if   response,
    output int   errors,
    output int   pending
);

    localparam int unsigned ARENA = fha_pkg::ARENA_BYTES;
    localparam int unsigned HDR   = fha_pkg::HEADER_BYTES;

    typedef struct {
        logic                         op;
        logic [fha_pkg::FIELD_W-1:0]  size;
        logic [fha_pkg::FIELD_W-1:0]  addr;
    } heap_req_t;

    typedef struct {
        logic [fha_pkg::STATUS_W-1:0] status;
        logic [fha_pkg::FIELD_W-1:0]  payload;
        logic [fha_pkg::FIELD_W-1:0]  bytes;
    } heap_rsp_t;

    logic [fha_pkg::LINK_W-1:0] head_ptr;
    logic [fha_pkg::SIZE_W-1:0] blk_size [fha_pkg::ARENA_BYTES];
    logic [fha_pkg::LINK_W-1:0] blk_link [fha_pkg::ARENA_BYTES];
    heap_rsp_t                  rsp_queue [$];

    function automatic int unsigned fix_link(input int unsigned v);
        return (v < ARENA) ? v : ARENA;
    endfunction

    // Applies one transaction to the shadow free list and returns its response.
    function automatic heap_rsp_t run_heap_op(input heap_req_t r);
        heap_rsp_t   e;
        int unsigned need, cur, prev, steps, split, nxt, blk;
        bit          found;
        e = '{fha_pkg::STATUS_DONE, '0, '0};
        prev = ARENA;
        steps = 0;
        found = 0;
        if (r.op == fha_pkg::OP_ALLOC)
        begin
            need = r.size + HDR;
            cur = fix_link(head_ptr);
            while (cur < ARENA && steps < ARENA)
            begin
                if (blk_size[cur] == need || (blk_size[cur] > need && cur + need < ARENA))
                begin
                    found = 1;
                    break;
                end
                prev = cur;
                cur = fix_link(blk_link[cur]);
                steps++;
            end
            if (!found)
            begin
                e.status = fha_pkg::STATUS_NOMEM;
            end
            else
            begin
                if (blk_size[cur] == need)
                begin
                    nxt = fix_link(blk_link[cur]);
                end
                else
                begin
                    split = cur + need;
                    blk_size[split] = blk_size[cur] - need;
                    blk_link[split] = fix_link(blk_link[cur]);
                    blk_size[cur] = r.size;
                    nxt = split;
                end
                if (prev == ARENA)
                    head_ptr = nxt;
                else
                    blk_link[prev] = nxt;
                blk_link[cur] = fha_pkg::LINK_NULL;
                e.payload = fha_pkg::FIELD_W'(cur + HDR);
                e.bytes = r.size;
            end
        end
        else if (r.addr < HDR || r.addr - HDR >= ARENA)
        begin
            e.status = fha_pkg::STATUS_BADBLK;
        end
        else
        begin
            blk = r.addr - HDR;
            cur = fix_link(head_ptr);
            while (cur < ARENA && cur < blk && steps < ARENA)
            begin
                prev = cur;
                cur = fix_link(blk_link[cur]);
                steps++;
            end
            blk_link[blk] = cur;
            if (prev == ARENA)
                head_ptr = blk;
            else
                blk_link[prev] = blk;
            e.bytes = blk_size[blk];
            // Coalesce every pair of neighbors that touch.
            cur = head_ptr;
            steps = 0;
            while (cur < ARENA && steps < 2 * ARENA)
            begin
                nxt = blk_link[cur];
                if (nxt >= ARENA)
                    break;
                if (cur + blk_size[cur] + HDR == nxt)
                begin
                    blk_size[cur] = blk_size[cur] + blk_size[nxt] + HDR;
                    blk_link[cur] = fix_link(blk_link[nxt]);
                end
                else
                begin
                    cur = nxt;
                end
                steps++;
            end
        end
        return e;
    endfunction

    // Handshake signals only change at the rising edge, so the falling edge
    // sees what the next rising edge will accept.
    always @(negedge clk)
    begin
        heap_req_t r;
        heap_rsp_t e;
        if (!rst_n)
        begin
            errors = 0;
            head_ptr = '0;
            for (int i = 0; i < fha_pkg::ARENA_BYTES; i++)
            begin
                blk_size[i] = '0;
                blk_link[i] = '0;
            end
            blk_size[0] = fha_pkg::SIZE_RESET;
            blk_link[0] = fha_pkg::LINK_NULL;
            rsp_queue.delete();
        end
        else
        begin
            if (request.valid && request.ready)
            begin
                r = '{request.operation, request.request_size, request.block_address};
                rsp_queue.push_back(run_heap_op(r));
            end
            if (response.valid && response.ready)
            begin
                if (rsp_queue.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    errors++;
                end
                else
                begin
                    e = rsp_queue.pop_front();
                    if (response.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, response.status);
                        errors++;
                    end
                    if (response.payload_address !== e.payload)
                    begin
                        $error("payload_address: expected %0d, got %0d",
                               e.payload, response.payload_address);
                        errors++;
                    end
                    if (response.block_bytes !== e.bytes)
                    begin
                        $error("block_bytes: expected %0d, got %0d",
                               e.bytes, response.block_bytes);
                        errors++;
                    end
                end
            end
        end
        pending = rsp_queue.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    int   hold_req = 0;
    int   hold_done = 0;
    int   quiet_cycles;
    logic [fha_pkg::FIELD_W-1:0] live_blocks [$];

    fha_req_if req_ch ();
    fha_rsp_if rsp_ch ();

    first_fit_heap_allocator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    fha_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_op(input logic op, input int size, input int addr);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.request_size <= fha_pkg::FIELD_W'(size);
        req_ch.block_address <= fha_pkg::FIELD_W'(addr);
        do
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // The count of outstanding responses only changes at the falling edge.
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Allocated payload offsets, so that random frees hit real blocks only once.
    always @(negedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == fha_pkg::STATUS_DONE
                && rsp_ch.payload_address != 0)
            live_blocks.push_back(rsp_ch.payload_address);
    end

    always @(negedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("first_fit_heap_allocator: mismatch");
            $finish;
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int pick;
        int size;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = fha_pkg::OP_ALLOC;
        req_ch.request_size = '0;
        req_ch.block_address = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Whole-arena exact fit, empty list, null and undersized frees, splits,
        // out-of-order frees that coalesce back into one block.
        send_op(fha_pkg::OP_ALLOC, 2016, 0);
        send_op(fha_pkg::OP_ALLOC, 0, 2047);
        send_op(fha_pkg::OP_FREE, 0, 16);
        send_op(fha_pkg::OP_FREE, 0, 0);
        send_op(fha_pkg::OP_FREE, 2047, 5);
        send_op(fha_pkg::OP_FREE, 0, 15);
        send_op(fha_pkg::OP_ALLOC, 0, 0);
        send_op(fha_pkg::OP_ALLOC, 100, 0);
        send_op(fha_pkg::OP_ALLOC, 200, 0);
        send_op(fha_pkg::OP_ALLOC, 2047, 0);
        send_op(fha_pkg::OP_FREE, 0, 32);
        send_op(fha_pkg::OP_FREE, 0, 16);
        send_op(fha_pkg::OP_FREE, 0, 148);
        send_op(fha_pkg::OP_ALLOC, 2017, 0);
        send_op(fha_pkg::OP_ALLOC, 2016, 0);
        send_op(fha_pkg::OP_FREE, 0, 16);
        req_ch.valid <= 1'b0;
        drain();
        live_blocks.delete();

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1 || phase == 3) ? 59 : 0;
            stall_pct = (phase == 2) ? 59 : (phase == 3) ? 37 : 0;
            if (phase == 3)
                idle_pct = 37;
            if (phase == 0)
                hold_req++;
            for (int n = 0; n < 175; n++)
            begin
                if (live_blocks.size() > 0 && $urandom_range(1) == 1)
                begin
                    pick = $urandom_range(live_blocks.size() - 1);
                    send_op(fha_pkg::OP_FREE, $urandom_range(2047), live_blocks[pick]);
                    live_blocks.delete(pick);
                end
                else if ($urandom_range(19) == 0)
                begin
                    send_op(fha_pkg::OP_FREE, $urandom_range(2047), $urandom_range(15));
                end
                else
                begin
                    pick = $urandom_range(9);
                    size = (pick < 7) ? $urandom_range(64)
                         : (pick < 9) ? $urandom_range(400) : $urandom_range(2047);
                    send_op(fha_pkg::OP_ALLOC, size, $urandom_range(2047));
                end
            end
        end
        req_ch.valid <= 1'b0;
        drain();

        if (errors == 0)
            $display("first_fit_heap_allocator: match");
        else
            $display("first_fit_heap_allocator: mismatch");
        $finish;
    end

endmodule
